// ===== src/dual_channel_byte_fifo_with_end_marker_defines.svh =====
`ifndef DUAL_CHANNEL_BYTE_FIFO_WITH_END_MARKER_DEFINES_SVH
`define DUAL_CHANNEL_BYTE_FIFO_WITH_END_MARKER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DCBF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define DCBF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/dcbf_pkg.sv =====
`timescale 1ns / 1ps

package dcbf_pkg;

    localparam int FIFO_DEPTH = 64;
    localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int ADDR_W     = $clog2(2 * FIFO_DEPTH);
    localparam int IDX_W      = 6;
    localparam int CNT_OUT_W  = 7;

    typedef enum logic [2:0] {
        FN_PUSH    = 3'd0,
        FN_POP     = 3'd1,
        FN_SET_END = 3'd2,
        FN_QUERY   = 3'd3,
        FN_CLEAR   = 3'd4
    } func_t;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } ctl_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_stat_t;

    function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(FIFO_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

endpackage

// ===== src/dcbf_ctrl.sv =====
`timescale 1ns / 1ps

module dcbf_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  dcbf_pkg::dp_stat_t stat,
    output dcbf_pkg::ctl_cmd_t cmd,
    output logic               s_ready
);
    import dcbf_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // stay until the result register can take the word
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        cmd.load = 1'b0;
        cmd.exec = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_EXEC: begin
                cmd.exec = stat.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== src/dcbf_datapath.sv =====
`timescale 1ns / 1ps

module dcbf_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [7:0]         cfg_wr_data,
    input  logic [2:0]         s_func,
    input  logic               s_channel,
    input  logic [7:0]         s_data_in,
    input  logic               s_flag_value,
    input  dcbf_pkg::ctl_cmd_t cmd,
    output dcbf_pkg::dp_stat_t stat,
    input  logic               m_ready,
    output logic               m_valid,
    output logic [7:0]         m_read_byte,
    output logic               m_push_dropped,
    output logic               m_is_full,
    output logic               m_is_empty,
    output logic               m_end_seen,
    output logic [5:0]         m_head_index,
    output logic [5:0]         m_tail_index,
    output logic [6:0]         m_fill_count
);
    import dcbf_pkg::*;

    logic [7:0]       mem [2*FIFO_DEPTH];
    logic [7:0]       rdata_reg;

    logic [7:0]       eol_char_reg;
    logic [PTR_W-1:0] wr_ptr_reg [2];
    logic [PTR_W-1:0] rd_ptr_reg [2];
    logic [1:0]       full_reg;
    logic [1:0]       end_reg;

    func_t            func_reg;
    logic             ch_reg;
    logic [7:0]       data_reg;
    logic             flag_reg;

    logic             m_valid_reg;
    logic [7:0]       read_byte_reg;
    logic             dropped_reg;
    logic             full_out_reg;
    logic             empty_out_reg;
    logic             end_out_reg;
    logic [5:0]       head_reg;
    logic [5:0]       tail_reg;
    logic [6:0]       count_reg;

    logic [PTR_W-1:0] wp;
    logic [PTR_W-1:0] rp;
    logic             full;
    logic             endm;
    logic [PTR_W-1:0] wp_next;
    logic [PTR_W-1:0] rp_next;
    logic             full_next;
    logic             end_next;
    logic             empty_next;
    logic [CNT_W-1:0] count_next;
    logic [7:0]       rd_byte;
    logic             dropped;
    logic             wr_en;
    logic [7:0]       wr_byte;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [IDX_W+PTR_W-1:0]     head_pad;
    logic [IDX_W+PTR_W-1:0]     tail_pad;
    logic [CNT_OUT_W+CNT_W-1:0] count_pad;

    assign stat.out_free = !m_valid_reg || m_ready;

    // read address comes straight off the port so the byte is ready next cycle
    assign rd_addr = s_channel ? (ADDR_W'(FIFO_DEPTH) + ADDR_W'(rd_ptr_reg[s_channel]))
                               : ADDR_W'(rd_ptr_reg[s_channel]);
    assign wr_addr = ch_reg ? (ADDR_W'(FIFO_DEPTH) + ADDR_W'(wp)) : ADDR_W'(wp);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rdata_reg <= mem[rd_addr];
        end
        if (cmd.exec && wr_en) begin
            mem[wr_addr] <= wr_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= func_t'(s_func);
            ch_reg   <= s_channel;
            data_reg <= s_data_in;
            flag_reg <= s_flag_value;
        end
    end

    always_comb begin
        wp         = wr_ptr_reg[ch_reg];
        rp         = rd_ptr_reg[ch_reg];
        full       = full_reg[ch_reg];
        endm       = end_reg[ch_reg];
        wp_next    = wp;
        rp_next    = rp;
        full_next  = full;
        end_next   = endm;
        rd_byte    = '0;
        dropped    = 1'b0;
        wr_en      = 1'b0;
        wr_byte    = data_reg;
        case (func_reg)
            FN_PUSH: begin
                if (full) begin
                    dropped = 1'b1;
                end else begin
                    // end character goes in as zero and raises the flag
                    if (data_reg == eol_char_reg) begin
                        wr_byte  = '0;
                        end_next = 1'b1;
                    end
                    wr_en     = 1'b1;
                    wp_next   = ptr_advance(wp);
                    full_next = (ptr_advance(wp) == rp);
                end
            end
            FN_POP: begin
                if (!((wp == rp) && !full)) begin
                    rd_byte   = rdata_reg;
                    rp_next   = ptr_advance(rp);
                    full_next = 1'b0;
                end
            end
            FN_SET_END: begin
                end_next = flag_reg;
            end
            FN_CLEAR: begin
                wp_next   = '0;
                rp_next   = '0;
                full_next = 1'b0;
                end_next  = 1'b0;
            end
            default: begin
                end_next = endm;
            end
        endcase

        empty_next = (wp_next == rp_next) && !full_next;
        if (full_next) begin
            count_next = CNT_W'(FIFO_DEPTH);
        end else if (wp_next >= rp_next) begin
            count_next = CNT_W'(wp_next - rp_next);
        end else begin
            count_next = CNT_W'(FIFO_DEPTH) - CNT_W'(rp_next - wp_next);
        end

        head_pad  = {{IDX_W{1'b0}}, wp_next};
        tail_pad  = {{IDX_W{1'b0}}, rp_next};
        count_pad = {{CNT_OUT_W{1'b0}}, count_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eol_char_reg  <= 8'd10;
            wr_ptr_reg[0] <= '0;
            wr_ptr_reg[1] <= '0;
            rd_ptr_reg[0] <= '0;
            rd_ptr_reg[1] <= '0;
            full_reg      <= '0;
            end_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                eol_char_reg <= cfg_wr_data;
            end
            if (cmd.exec) begin
                wr_ptr_reg[ch_reg] <= wp_next;
                rd_ptr_reg[ch_reg] <= rp_next;
                full_reg[ch_reg]   <= full_next;
                end_reg[ch_reg]    <= end_next;
                m_valid_reg        <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            read_byte_reg <= rd_byte;
            dropped_reg   <= dropped;
            full_out_reg  <= full_next;
            empty_out_reg <= empty_next;
            end_out_reg   <= end_next;
            head_reg      <= head_pad[IDX_W-1:0];
            tail_reg      <= tail_pad[IDX_W-1:0];
            count_reg     <= count_pad[CNT_OUT_W-1:0];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_read_byte    = read_byte_reg;
    assign m_push_dropped = dropped_reg;
    assign m_is_full      = full_out_reg;
    assign m_is_empty     = empty_out_reg;
    assign m_end_seen     = end_out_reg;
    assign m_head_index   = head_reg;
    assign m_tail_index   = tail_reg;
    assign m_fill_count   = count_reg;

endmodule

// ===== src/dual_channel_byte_fifo_with_end_marker.sv =====
// Two byte FIFOs of 64 entries each, receive on channel 0 and transmit on channel 1, sharing
// one byte store. Each input word runs one operation (push, pop, set end flag, query, clear)
// on the FIFO its channel bit selects and returns one result word with the byte popped and
// the status after the operation. A pushed byte equal to the end character is stored as zero
// and sets the end flag; a push into a full FIFO is dropped and flagged; a pop from an empty
// FIFO returns zero. Each word first reads the shared store at the selected read position into
// its output register, then updates the pointers and loads the result register; the next word
// is accepted only once this update is done. The result register holds a finished word while
// the next input word is accepted; the block stalls only if that result is still waiting when
// the next one is done. The end character, written through cfg_wr_en and cfg_wr_data, resets
// to 10; the user must write it only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps
`include "dual_channel_byte_fifo_with_end_marker_defines.svh"

module dual_channel_byte_fifo_with_end_marker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_func,
    input  logic       s_channel,
    input  logic [7:0] s_data_in,
    input  logic       s_flag_value,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_byte,
    output logic       m_push_dropped,
    output logic       m_is_full,
    output logic       m_is_empty,
    output logic       m_end_seen,
    output logic [5:0] m_head_index,
    output logic [5:0] m_tail_index,
    output logic [6:0] m_fill_count
);
    import dcbf_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;

    dcbf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .stat    (stat),
        .cmd     (cmd),
        .s_ready (s_ready)
    );

    dcbf_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_func         (s_func),
        .s_channel      (s_channel),
        .s_data_in      (s_data_in),
        .s_flag_value   (s_flag_value),
        .cmd            (cmd),
        .stat           (stat),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_read_byte    (m_read_byte),
        .m_push_dropped (m_push_dropped),
        .m_is_full      (m_is_full),
        .m_is_empty     (m_is_empty),
        .m_end_seen     (m_end_seen),
        .m_head_index   (m_head_index),
        .m_tail_index   (m_tail_index),
        .m_fill_count   (m_fill_count)
    );

    // a word just accepted keeps the input side closed for its update cycle
    `DCBF_ASSERT_NEXT(a_busy_after_load, s_valid && s_ready, !s_ready, "input open during update")
    `DCBF_ASSERT_NOW(a_full_empty_excl, m_valid, !(m_is_full && m_is_empty), "full and empty")
    `DCBF_ASSERT_NOW(a_empty_count, m_valid && m_is_empty, m_fill_count == 7'd0, "empty count")
    `DCBF_ASSERT_NOW(a_drop_when_full, m_valid && m_push_dropped, m_is_full, "drop not full")

endmodule
